/* hdl/rdd36_pkg.sv */
`timescale 1ns / 1ps

package rdd36_pkg;

	// frame identifier 'icpf'
	localparam logic [31:0] FRAME_ID = 32'h6963_7066;

	// byte classes
	localparam logic [2:0] CLS_PREFIX  = 3'd0;
	localparam logic [2:0] CLS_FHDR    = 3'd1;
	localparam logic [2:0] CLS_LUMA    = 3'd2;
	localparam logic [2:0] CLS_CHROMA  = 3'd3;
	localparam logic [2:0] CLS_PHDR    = 3'd4;
	localparam logic [2:0] CLS_PAYLOAD = 3'd5;
	localparam logic [2:0] CLS_STUFF   = 3'd6;
	localparam logic [2:0] CLS_ERROR   = 3'd7;

	// error codes
	localparam logic [2:0] ERR_NONE      = 3'd0;
	localparam logic [2:0] ERR_BAD_ID    = 3'd1;
	localparam logic [2:0] ERR_FHDR_SHORT = 3'd2;
	localparam logic [2:0] ERR_PSIZE_SHORT = 3'd3;
	localparam logic [2:0] ERR_PHDR_SHORT = 3'd4;

	// fixed segment lengths
	localparam logic [7:0] FHDR_FIXED_LEN = 8'd20;
	localparam logic [7:0] QMATRIX_LEN    = 8'd64;
	localparam logic [4:0] PHDR_FIXED_LEN = 5'd8;

	// one result item
	typedef struct packed {
		logic [2:0]  byte_class;
		logic [7:0]  data_out;
		logic        picture_index;
		logic        header_ready;
		logic        frame_done;
		logic [2:0]  error_code;
		logic [31:0] frame_total;
		logic [15:0] pic_width;
		logic [15:0] pic_height;
		logic [1:0]  chroma_fmt;
		logic [1:0]  ilace_mode;
		logic [31:0] pic_total;
	} result_t;

endpackage

/* hdl/rdd36_parser.sv */
`timescale 1ns / 1ps

module rdd36_parser (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                advance,
	input  logic [7:0]          data_byte,
	output rdd36_pkg::result_t  result
);
	import rdd36_pkg::*;

	typedef enum logic [10:0] {
		PH_FSIZE   = 11'b000_0000_0001,
		PH_FID     = 11'b000_0000_0010,
		PH_FHDR    = 11'b000_0000_0100,
		PH_LUMA    = 11'b000_0000_1000,
		PH_CHROMA  = 11'b000_0001_0000,
		PH_FHSKIP  = 11'b000_0010_0000,
		PH_PHDR    = 11'b000_0100_0000,
		PH_PHSKIP  = 11'b000_1000_0000,
		PH_PAYLOAD = 11'b001_0000_0000,
		PH_STUFF   = 11'b010_0000_0000,
		PH_ERROR   = 11'b100_0000_0000
	} phase_t;

	// outcome of closing a segment that hands over to another phase
	typedef struct packed {
		phase_t      ph;
		logic [31:0] rem;
		logic        restart;
		logic        second;
		logic        frame_end;
	} seg_t;

	// parser state
	phase_t      phase_q;
	logic [6:0]  idx_q;
	logic [31:0] rem_q;
	logic [31:0] flen_q;
	logic [31:0] fpos_q;
	logic [15:0] fhl_q;
	logic [31:0] acc_q;
	logic [15:0] width_q;
	logic [15:0] height_q;
	logic [1:0]  chroma_q;
	logic [1:0]  ilace_q;
	logic [1:0]  qm_q;
	logic [31:0] plen_q;
	logic [4:0]  phl_q;
	logic        cur_q;
	logic [2:0]  err_q;

	// next state
	phase_t      phase_n;
	logic [6:0]  idx_n;
	logic [31:0] rem_n;
	logic [31:0] flen_n;
	logic [31:0] fpos_n;
	logic [15:0] fhl_n;
	logic [31:0] acc_n;
	logic [15:0] width_n;
	logic [15:0] height_n;
	logic [1:0]  chroma_n;
	logic [1:0]  ilace_n;
	logic [1:0]  qm_n;
	logic [31:0] plen_n;
	logic [4:0]  phl_n;
	logic        cur_n;
	logic [2:0]  err_n;

	logic [2:0]  cls;
	logic        pic;
	logic        hdr_p;
	logic        frm_p;

	logic        frame_start;
	logic [31:0] fpos_base;
	logic [31:0] stuff_len;
	logic        has_stuff;
	logic        two_pics;
	logic [31:0] payload_len;
	logic [7:0]  need;
	logic [15:0] fh_skip;
	logic [4:0]  ph_skip;
	logic [31:0] acc_shift;
	seg_t        end_pic;
	seg_t        enter_pay;
	seg_t        end_fhdr;
	seg_t        after_mat;
	seg_t        go;
	logic        take;

	// frame byte position, cleared at the first byte of a frame
	assign frame_start = (phase_q == PH_FSIZE) && (idx_q == 7'd0);
	assign fpos_base   = frame_start ? 32'd0 : fpos_q;
	assign fpos_n      = ((phase_q != PH_ERROR) && (fpos_base != 32'hFFFF_FFFF))
		? fpos_base + 32'd1 : fpos_base;

	assign acc_shift = {acc_q[23:0], data_byte};

	// end of a picture: second field, stuffing or end of frame
	assign two_pics  = !cur_q && ((ilace_q == 2'd1) || (ilace_q == 2'd2));
	assign has_stuff = fpos_n < flen_q;
	assign stuff_len = flen_q - fpos_n;

	always_comb begin
		end_pic = '{ph: PH_FSIZE, rem: rem_q, restart: 1'b1, second: 1'b0,
			frame_end: 1'b1};
		if (two_pics) begin
			end_pic = '{ph: PH_PHDR, rem: rem_q, restart: 1'b1, second: 1'b1,
				frame_end: 1'b0};
		end else if (has_stuff) begin
			end_pic = '{ph: PH_STUFF, rem: stuff_len, restart: 1'b0, second: 1'b0,
				frame_end: 1'b0};
		end
	end

	// start of payload, which may be empty
	assign payload_len = plen_q - {27'd0, phl_q};

	always_comb begin
		if (payload_len == 32'd0) begin
			enter_pay = end_pic;
		end else begin
			enter_pay = '{ph: PH_PAYLOAD, rem: payload_len, restart: 1'b0,
				second: 1'b0, frame_end: 1'b0};
		end
	end

	// end of frame header opens the first picture
	assign end_fhdr = '{ph: PH_PHDR, rem: rem_q, restart: 1'b1, second: 1'b0,
		frame_end: 1'b0};

	// bytes of frame header left after the matrices
	assign need    = FHDR_FIXED_LEN + (qm_n[1] ? QMATRIX_LEN : 8'd0)
		+ (qm_n[0] ? QMATRIX_LEN : 8'd0);
	assign fh_skip = fhl_n - {8'd0, need};

	always_comb begin
		if (fh_skip == 16'd0) begin
			after_mat = end_fhdr;
		end else begin
			after_mat = '{ph: PH_FHSKIP, rem: {16'd0, fh_skip}, restart: 1'b0,
				second: 1'b0, frame_end: 1'b0};
		end
	end

	assign ph_skip = phl_n - PHDR_FIXED_LEN;

	// next state and result for the byte at hand
	always_comb begin
		phase_n  = phase_q;
		idx_n    = idx_q;
		rem_n    = rem_q;
		flen_n   = flen_q;
		fhl_n    = fhl_q;
		acc_n    = acc_q;
		width_n  = width_q;
		height_n = height_q;
		chroma_n = chroma_q;
		ilace_n  = ilace_q;
		qm_n     = qm_q;
		plen_n   = plen_q;
		phl_n    = phl_q;
		cur_n    = frame_start ? 1'b0 : cur_q;
		err_n    = err_q;
		cls      = CLS_ERROR;
		pic      = 1'b0;
		hdr_p    = 1'b0;
		go       = end_pic;
		take     = 1'b0;

		unique case (phase_q)
			PH_FSIZE: begin
				cls   = CLS_PREFIX;
				acc_n = acc_shift;
				idx_n = idx_q + 7'd1;
				if (idx_q == 7'd3) begin
					flen_n  = acc_shift;
					acc_n   = '0;
					idx_n   = '0;
					phase_n = PH_FID;
				end
			end
			PH_FID: begin
				cls   = CLS_PREFIX;
				acc_n = acc_shift;
				idx_n = idx_q + 7'd1;
				if (idx_q == 7'd3) begin
					idx_n = '0;
					if (acc_shift != FRAME_ID) begin
						err_n   = ERR_BAD_ID;
						phase_n = PH_ERROR;
					end else begin
						acc_n   = '0;
						phase_n = PH_FHDR;
					end
				end
			end
			PH_FHDR: begin
				cls = CLS_FHDR;
				case (idx_q)
					7'd0:  fhl_n = {data_byte, 8'd0};
					7'd1:  fhl_n = {fhl_q[15:8], data_byte};
					7'd8:  width_n = {data_byte, 8'd0};
					7'd9:  width_n = {width_q[15:8], data_byte};
					7'd10: height_n = {data_byte, 8'd0};
					7'd11: height_n = {height_q[15:8], data_byte};
					7'd12: begin
						chroma_n = data_byte[7:6];
						ilace_n  = data_byte[3:2];
					end
					7'd19: qm_n = data_byte[1:0];
					default: ;
				endcase
				idx_n = idx_q + 7'd1;
				if (idx_q == 7'd19) begin
					idx_n = '0;
					if (fhl_n < {8'd0, need}) begin
						err_n   = ERR_FHDR_SHORT;
						phase_n = PH_ERROR;
					end else if (qm_n[1]) begin
						phase_n = PH_LUMA;
					end else if (qm_n[0]) begin
						phase_n = PH_CHROMA;
					end else begin
						go   = after_mat;
						take = 1'b1;
					end
				end
			end
			PH_LUMA: begin
				cls   = CLS_LUMA;
				idx_n = idx_q + 7'd1;
				if (idx_q == 7'd63) begin
					idx_n = '0;
					if (qm_q[0]) begin
						phase_n = PH_CHROMA;
					end else begin
						go   = after_mat;
						take = 1'b1;
					end
				end
			end
			PH_CHROMA: begin
				cls   = CLS_CHROMA;
				idx_n = idx_q + 7'd1;
				if (idx_q == 7'd63) begin
					idx_n = '0;
					go    = after_mat;
					take  = 1'b1;
				end
			end
			PH_FHSKIP: begin
				cls = CLS_FHDR;
				if (rem_q <= 32'd1) begin
					go   = end_fhdr;
					take = 1'b1;
				end else begin
					rem_n = rem_q - 32'd1;
				end
			end
			PH_PHDR: begin
				cls = CLS_PHDR;
				pic = cur_q;
				if (idx_q == 7'd0) begin
					phl_n = data_byte[7:3];
				end else if (idx_q <= 7'd4) begin
					acc_n = acc_shift;
					if (idx_q == 7'd4) begin
						plen_n = acc_shift;
					end
				end
				idx_n = idx_q + 7'd1;
				if (idx_q == 7'd7) begin
					idx_n = '0;
					acc_n = '0;
					if (plen_n < {27'd0, phl_n}) begin
						err_n   = ERR_PSIZE_SHORT;
						phase_n = PH_ERROR;
					end else if (phl_n < PHDR_FIXED_LEN) begin
						err_n   = ERR_PHDR_SHORT;
						phase_n = PH_ERROR;
					end else if (ph_skip == 5'd0) begin
						go   = enter_pay;
						take = 1'b1;
					end else begin
						rem_n   = {27'd0, ph_skip};
						phase_n = PH_PHSKIP;
					end
				end
			end
			PH_PHSKIP: begin
				cls = CLS_PHDR;
				pic = cur_q;
				if (rem_q <= 32'd1) begin
					go   = enter_pay;
					take = 1'b1;
				end else begin
					rem_n = rem_q - 32'd1;
				end
			end
			PH_PAYLOAD: begin
				cls = CLS_PAYLOAD;
				pic = cur_q;
				if (rem_q <= 32'd1) begin
					go   = end_pic;
					take = 1'b1;
				end else begin
					rem_n = rem_q - 32'd1;
				end
			end
			PH_STUFF: begin
				cls = CLS_STUFF;
				if (rem_q <= 32'd1) begin
					go   = '{ph: PH_FSIZE, rem: rem_q, restart: 1'b1, second: 1'b0,
						frame_end: 1'b1};
					take = 1'b1;
				end else begin
					rem_n = rem_q - 32'd1;
				end
			end
			PH_ERROR: begin
				cls = CLS_ERROR;
			end
			default: begin
				phase_n = PH_ERROR;
			end
		endcase

		// apply a segment handover
		frm_p = 1'b0;
		if (take) begin
			phase_n = go.ph;
			rem_n   = go.rem;
			frm_p   = go.frame_end;
			if (go.restart) begin
				idx_n = '0;
				acc_n = '0;
			end
			if (go.ph == PH_PHDR) begin
				cur_n = go.second;
				hdr_p = !go.second;
			end
		end
	end

	// result fields, masked once an error has been seen
	always_comb begin
		result.byte_class    = (err_n != ERR_NONE) ? CLS_ERROR : cls;
		result.data_out      = data_byte;
		result.picture_index = (err_n != ERR_NONE) ? 1'b0 : pic;
		result.header_ready  = (err_n != ERR_NONE) ? 1'b0 : hdr_p;
		result.frame_done    = (err_n != ERR_NONE) ? 1'b0 : frm_p;
		result.error_code    = err_n;
		result.frame_total   = flen_n;
		result.pic_width     = width_n;
		result.pic_height    = height_n;
		result.chroma_fmt    = chroma_n;
		result.ilace_mode    = ilace_n;
		result.pic_total     = plen_n;
	end

	// state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_FSIZE;
			idx_q    <= '0;
			rem_q    <= '0;
			flen_q   <= '0;
			fpos_q   <= '0;
			fhl_q    <= '0;
			acc_q    <= '0;
			width_q  <= '0;
			height_q <= '0;
			chroma_q <= '0;
			ilace_q  <= '0;
			qm_q     <= '0;
			plen_q   <= '0;
			phl_q    <= '0;
			cur_q    <= 1'b0;
			err_q    <= ERR_NONE;
		end else if (advance) begin
			phase_q  <= phase_n;
			idx_q    <= idx_n;
			rem_q    <= rem_n;
			flen_q   <= flen_n;
			fpos_q   <= fpos_n;
			fhl_q    <= fhl_n;
			acc_q    <= acc_n;
			width_q  <= width_n;
			height_q <= height_n;
			chroma_q <= chroma_n;
			ilace_q  <= ilace_n;
			qm_q     <= qm_n;
			plen_q   <= plen_n;
			phl_q    <= phl_n;
			cur_q    <= cur_n;
			err_q    <= err_n;
		end
	end

endmodule

/* hdl/rdd36_frame_deframer_core.sv */
`timescale 1ns / 1ps

// channel  | handshake                  | payload
// ---------+----------------------------+--------------------------------------
// input    | data_valid / data_ready    | data_byte
// output   | result_valid / result_ready| byte_class .. pic_total
//
// one byte per clock sustained while result_ready is high.
// stage 1 registers the input byte, the parser classifies it and updates its
// state, and stage 2 registers the result item.
// reset clears the parser to the frame size phase with all header values zero.
// a stalled output holds stage 2; stage 1 then fills and input ready drops.
// an error is sticky until reset.

module rdd36_frame_deframer_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        data_valid,
	output logic        data_ready,
	input  logic [7:0]  data_byte,
	output logic        result_valid,
	input  logic        result_ready,
	output logic [2:0]  byte_class,
	output logic [7:0]  data_out,
	output logic        picture_index,
	output logic        header_ready,
	output logic        frame_done,
	output logic [2:0]  error_code,
	output logic [31:0] frame_total,
	output logic [15:0] pic_width,
	output logic [15:0] pic_height,
	output logic [1:0]  chroma_fmt,
	output logic [1:0]  ilace_mode,
	output logic [31:0] pic_total
);
	import rdd36_pkg::*;

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       valid_s2;
	result_t    res_s2;
	result_t    res;
	logic       advance;

	// stage 1 moves on when stage 2 is free or being emptied
	assign advance    = valid_s1 && (!valid_s2 || result_ready);
	assign data_ready = !valid_s1 || advance;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (data_ready) begin
			valid_s1 <= data_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (data_ready && data_valid) begin
			byte_s1 <= data_byte;
		end
	end

	// parser
	rdd36_parser u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.advance   (advance),
		.data_byte (byte_s1),
		.result    (res)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (!valid_s2 || result_ready) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_s2 <= res;
		end
	end

	assign result_valid  = valid_s2;
	assign byte_class    = res_s2.byte_class;
	assign data_out      = res_s2.data_out;
	assign picture_index = res_s2.picture_index;
	assign header_ready  = res_s2.header_ready;
	assign frame_done    = res_s2.frame_done;
	assign error_code    = res_s2.error_code;
	assign frame_total   = res_s2.frame_total;
	assign pic_width     = res_s2.pic_width;
	assign pic_height    = res_s2.pic_height;
	assign chroma_fmt    = res_s2.chroma_fmt;
	assign ilace_mode    = res_s2.ilace_mode;
	assign pic_total     = res_s2.pic_total;

endmodule

/* tb/sv/tb.sv */
`timescale 1ns / 1ps

import rdd36_pkg::*;

// where the parser stands within a frame
typedef enum logic [3:0] {
	PH_SIZE, PH_IDENT, PH_FHDR, PH_LUMA, PH_CHROMA, PH_FHSKIP,
	PH_PHDR, PH_PHSKIP, PH_PAYLOAD, PH_STUFF, PH_ERROR
} parse_phase_t;

// how the frame size field relates to the frame content
typedef enum logic [1:0] {
	SIZE_EXACT, SIZE_PADDED, SIZE_SHORT, SIZE_GIVEN
} size_rule_t;

// everything needed to lay out one frame
typedef struct packed {
	logic [31:0]       ident;
	logic [15:0]       fh_bytes;
	logic [15:0]       width;
	logic [15:0]       height;
	logic [1:0]        chroma;
	logic [1:0]        interlace;
	logic [1:0]        qmats;
	logic [1:0][4:0]   ph_len;
	logic [1:0][31:0]  pic_bytes;
	size_rule_t        size_rule;
	logic [31:0]       size_value;
} frame_plan_t;

// tracks the frame structure byte by byte and checks every result item
class deframe_checker;
	parse_phase_t phase = PH_SIZE;
	int unsigned step_index = 0;
	logic [31:0] seg_left = '0;
	logic [31:0] frame_len = '0;
	logic [31:0] frame_count = '0;
	logic [31:0] accum = '0;
	logic [31:0] pic_len = '0;
	logic [15:0] fh_len = '0;
	logic [15:0] width = '0;
	logic [15:0] height = '0;
	logic [1:0] chroma = '0;
	logic [1:0] ilace = '0;
	logic [1:0] qmats = '0;
	logic [4:0] ph_len = '0;
	logic cur_pic = 1'b0;
	logic [2:0] err = ERR_NONE;
	bit hdr_pulse;
	bit frame_pulse;
	result_t pending_results[$];
	int mismatches = 0;

	function int unsigned header_need();
		return 20 + (qmats[1] ? 64 : 0) + (qmats[0] ? 64 : 0);
	endfunction

	function void raise_error(logic [2:0] code);
		err = code;
		phase = PH_ERROR;
	endfunction

	function void close_frame();
		frame_pulse = 1'b1;
		phase = PH_SIZE;
		step_index = 0;
		accum = '0;
	endfunction

	function void open_picture(logic which);
		cur_pic = which;
		phase = PH_PHDR;
		step_index = 0;
		accum = '0;
	endfunction

	function void end_header();
		hdr_pulse = 1'b1;
		open_picture(1'b0);
	endfunction

	// second field follows, else stuffing or the next frame
	function void close_picture();
		if (!cur_pic && (ilace == 2'd1 || ilace == 2'd2))
			open_picture(1'b1);
		else if (frame_count < frame_len) begin
			seg_left = frame_len - frame_count;
			phase = PH_STUFF;
		end else
			close_frame();
	endfunction

	function void enter_payload();
		seg_left = pic_len - 32'(ph_len);
		if (seg_left == 0)
			close_picture();
		else
			phase = PH_PAYLOAD;
	endfunction

	function void after_matrices();
		seg_left = 32'(fh_len) - header_need();
		if (seg_left == 0)
			end_header();
		else
			phase = PH_FHSKIP;
	endfunction

	// advance the parse by one accepted byte and queue its result
	function void take_byte(logic [7:0] b);
		result_t r;
		logic [2:0] cls;
		logic pic;
		cls = CLS_ERROR;
		pic = 1'b0;
		hdr_pulse = 1'b0;
		frame_pulse = 1'b0;
		if (phase == PH_SIZE && step_index == 0) begin
			frame_count = '0;
			cur_pic = 1'b0;
		end
		if (phase != PH_ERROR && frame_count != 32'hFFFF_FFFF)
			frame_count++;
		case (phase)
			PH_SIZE: begin
				cls = CLS_PREFIX;
				accum = {accum[23:0], b};
				step_index++;
				if (step_index >= 4) begin
					frame_len = accum;
					accum = '0;
					step_index = 0;
					phase = PH_IDENT;
				end
			end
			PH_IDENT: begin
				cls = CLS_PREFIX;
				accum = {accum[23:0], b};
				step_index++;
				if (step_index >= 4) begin
					step_index = 0;
					if (accum != FRAME_ID)
						raise_error(ERR_BAD_ID);
					else begin
						accum = '0;
						phase = PH_FHDR;
					end
				end
			end
			PH_FHDR: begin
				cls = CLS_FHDR;
				case (step_index)
					0: fh_len = {b, 8'h00};
					1: fh_len[7:0] = b;
					8: width = {b, 8'h00};
					9: width[7:0] = b;
					10: height = {b, 8'h00};
					11: height[7:0] = b;
					12: begin
						chroma = b[7:6];
						ilace = b[3:2];
					end
					19: qmats = b[1:0];
					default: ;
				endcase
				step_index++;
				if (step_index >= 20) begin
					step_index = 0;
					if (32'(fh_len) < header_need())
						raise_error(ERR_FHDR_SHORT);
					else if (qmats[1])
						phase = PH_LUMA;
					else if (qmats[0])
						phase = PH_CHROMA;
					else
						after_matrices();
				end
			end
			PH_LUMA: begin
				cls = CLS_LUMA;
				step_index++;
				if (step_index >= 64) begin
					step_index = 0;
					if (qmats[0])
						phase = PH_CHROMA;
					else
						after_matrices();
				end
			end
			PH_CHROMA: begin
				cls = CLS_CHROMA;
				step_index++;
				if (step_index >= 64) begin
					step_index = 0;
					after_matrices();
				end
			end
			PH_FHSKIP: begin
				cls = CLS_FHDR;
				if (seg_left <= 1)
					end_header();
				else
					seg_left--;
			end
			PH_PHDR: begin
				cls = CLS_PHDR;
				pic = cur_pic;
				if (step_index == 0)
					ph_len = b[7:3];
				else if (step_index <= 4) begin
					accum = {accum[23:0], b};
					if (step_index == 4)
						pic_len = accum;
				end
				step_index++;
				if (step_index >= 8) begin
					step_index = 0;
					accum = '0;
					if (pic_len < 32'(ph_len))
						raise_error(ERR_PSIZE_SHORT);
					else if (ph_len < PHDR_FIXED_LEN)
						raise_error(ERR_PHDR_SHORT);
					else begin
						seg_left = 32'(ph_len) - 32'(PHDR_FIXED_LEN);
						if (seg_left == 0)
							enter_payload();
						else
							phase = PH_PHSKIP;
					end
				end
			end
			PH_PHSKIP: begin
				cls = CLS_PHDR;
				pic = cur_pic;
				if (seg_left <= 1)
					enter_payload();
				else
					seg_left--;
			end
			PH_PAYLOAD: begin
				cls = CLS_PAYLOAD;
				pic = cur_pic;
				if (seg_left <= 1)
					close_picture();
				else
					seg_left--;
			end
			PH_STUFF: begin
				cls = CLS_STUFF;
				if (seg_left <= 1)
					close_frame();
				else
					seg_left--;
			end
			default: phase = PH_ERROR;
		endcase

		// a sticky error overrides the classification
		if (err != ERR_NONE) begin
			cls = CLS_ERROR;
			pic = 1'b0;
			hdr_pulse = 1'b0;
			frame_pulse = 1'b0;
		end

		r.byte_class = cls;
		r.data_out = b;
		r.picture_index = pic;
		r.header_ready = hdr_pulse;
		r.frame_done = frame_pulse;
		r.error_code = err;
		r.frame_total = frame_len;
		r.pic_width = width;
		r.pic_height = height;
		r.chroma_fmt = chroma;
		r.ilace_mode = ilace;
		r.pic_total = pic_len;
		pending_results.push_back(r);
	endfunction

	function string describe(result_t r);
		return $sformatf({"cls=%0d data=%h pic=%0d hdr=%0d done=%0d err=%0d ",
			"fsize=%h w=%h h=%h chroma=%0d ilace=%0d psize=%h"},
			r.byte_class, r.data_out, r.picture_index, r.header_ready, r.frame_done,
			r.error_code, r.frame_total, r.pic_width, r.pic_height,
			r.chroma_fmt, r.ilace_mode, r.pic_total);
	endfunction

	// compare one result item with the oldest expectation
	function void check_item(result_t got);
		result_t want;
		if (pending_results.size() == 0) begin
			mismatches++;
			if (mismatches <= 10)
				$display("unexpected result: %s", describe(got));
			return;
		end
		want = pending_results.pop_front();
		if (got.byte_class !== want.byte_class || got.data_out !== want.data_out ||
				got.picture_index !== want.picture_index ||
				got.header_ready !== want.header_ready ||
				got.frame_done !== want.frame_done || got.error_code !== want.error_code ||
				got.frame_total !== want.frame_total ||
				got.pic_width !== want.pic_width ||
				got.pic_height !== want.pic_height ||
				got.chroma_fmt !== want.chroma_fmt ||
				got.ilace_mode !== want.ilace_mode ||
				got.pic_total !== want.pic_total) begin
			mismatches++;
			if (mismatches <= 10)
				$display("result mismatch\n  expected %s\n  actual   %s",
					describe(want), describe(got));
		end
	endfunction
endclass

module tb;

	localparam int STALL_LIMIT = 2000;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        data_valid = 1'b0;
	logic        data_ready;
	logic [7:0]  data_byte = 8'h00;
	logic        result_valid;
	logic        result_ready = 1'b0;
	logic [2:0]  byte_class;
	logic [7:0]  data_out;
	logic        picture_index;
	logic        header_ready;
	logic        frame_done;
	logic [2:0]  error_code;
	logic [31:0] frame_total;
	logic [15:0] pic_width;
	logic [15:0] pic_height;
	logic [1:0]  chroma_fmt;
	logic [1:0]  ilace_mode;
	logic [31:0] pic_total;

	result_t seen;
	deframe_checker ledger = new;
	logic [7:0] pending_bytes[$];
	bit gaps_on = 1'b1;
	int bytes_sent = 0;
	int stall_left = 0;
	int quiet_cycles = 0;

	rdd36_frame_deframer_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.data_valid(data_valid),
		.data_ready(data_ready),
		.data_byte(data_byte),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.byte_class(byte_class),
		.data_out(data_out),
		.picture_index(picture_index),
		.header_ready(header_ready),
		.frame_done(frame_done),
		.error_code(error_code),
		.frame_total(frame_total),
		.pic_width(pic_width),
		.pic_height(pic_height),
		.chroma_fmt(chroma_fmt),
		.ilace_mode(ilace_mode),
		.pic_total(pic_total)
	);

	always #5 clk = ~clk;

	assign seen = {byte_class, data_out, picture_index, header_ready, frame_done,
		error_code, frame_total, pic_width, pic_height, chroma_fmt,
		ilace_mode, pic_total};

	// result side: random stall bursts
	always @(negedge clk) begin
		if (stall_left != 0) begin
			result_ready <= 1'b0;
			stall_left <= stall_left - 1;
		end else if (gaps_on && $urandom_range(0, 5) == 0) begin
			result_ready <= 1'b0;
			stall_left <= $urandom_range(0, 15);
		end else
			result_ready <= 1'b1;
	end

	// check each accepted result item
	always @(posedge clk) begin
		if (result_valid === 1'b1 && result_ready)
			ledger.check_item(seen);
	end

	// watchdog on cycles without any handshake
	always @(posedge clk) begin
		if ((data_valid && data_ready === 1'b1) || (result_valid === 1'b1 && result_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("** rdd36_frame_deframer_core: FAILED **");
			$finish;
		end
	end

	// a well-formed frame with random content
	function automatic frame_plan_t random_plan();
		frame_plan_t p;
		int unsigned need;
		p.ident = FRAME_ID;
		p.width = 16'($urandom());
		p.height = 16'($urandom());
		p.chroma = 2'($urandom_range(0, 3));
		p.interlace = 2'($urandom_range(0, 3));
		p.qmats = ($urandom_range(0, 1) == 0) ? 2'd0 : 2'($urandom_range(1, 3));
		need = 20 + (p.qmats[1] ? 64 : 0) + (p.qmats[0] ? 64 : 0);
		p.fh_bytes = 16'(need + $urandom_range(0, 12));
		for (int k = 0; k < 2; k++) begin
			p.ph_len[k] = 5'($urandom_range(8, 31));
			p.pic_bytes[k] = 32'(p.ph_len[k]) + (($urandom_range(0, 9) == 0) ?
				$urandom_range(25, 200) : $urandom_range(0, 24));
		end
		p.size_rule = size_rule_t'($urandom_range(0, 2));
		p.size_value = (p.size_rule == SIZE_PADDED) ? $urandom_range(1, 20) : $urandom();
		return p;
	endfunction

	// lay out the bytes of one frame; a broken header ends the frame early
	function automatic void build_frame(frame_plan_t p);
		logic [7:0] body[$];
		int unsigned need;
		int unsigned npics;
		logic [31:0] fsize;
		bit bail;
		bail = 1'b0;
		for (int i = 3; i >= 0; i--)
			body.push_back(p.ident[8 * i +: 8]);
		if (p.ident != FRAME_ID)
			bail = 1'b1;
		if (!bail) begin
			body.push_back(p.fh_bytes[15:8]);
			body.push_back(p.fh_bytes[7:0]);
			repeat (6) body.push_back(8'($urandom()));
			body.push_back(p.width[15:8]);
			body.push_back(p.width[7:0]);
			body.push_back(p.height[15:8]);
			body.push_back(p.height[7:0]);
			body.push_back({p.chroma, 2'($urandom()), p.interlace, 2'($urandom())});
			repeat (6) body.push_back(8'($urandom()));
			body.push_back({6'($urandom()), p.qmats});
			need = 20 + (p.qmats[1] ? 64 : 0) + (p.qmats[0] ? 64 : 0);
			if (32'(p.fh_bytes) < need)
				bail = 1'b1;
			else
				repeat (32'(p.fh_bytes) - 20) body.push_back(8'($urandom()));
		end
		npics = (p.interlace == 2'd1 || p.interlace == 2'd2) ? 2 : 1;
		for (int k = 0; k < npics && !bail; k++) begin
			body.push_back({p.ph_len[k], 3'($urandom())});
			for (int i = 3; i >= 0; i--)
				body.push_back(p.pic_bytes[k][8 * i +: 8]);
			repeat (3) body.push_back(8'($urandom()));
			if (p.pic_bytes[k] < 32'(p.ph_len[k]) || p.ph_len[k] < PHDR_FIXED_LEN)
				bail = 1'b1;
			else begin
				repeat (32'(p.ph_len[k]) - 8) body.push_back(8'($urandom()));
				repeat (p.pic_bytes[k] - 32'(p.ph_len[k])) body.push_back(8'($urandom()));
			end
		end
		case (p.size_rule)
			SIZE_EXACT: fsize = 32'(body.size() + 4);
			SIZE_PADDED: fsize = 32'(body.size() + 4) + p.size_value;
			SIZE_SHORT: fsize = p.size_value % 32'(body.size() + 4);
			default: fsize = p.size_value;
		endcase
		for (int i = 0; i < 4; i++)
			body.push_front(fsize[8 * i +: 8]);
		if (p.size_rule == SIZE_PADDED)
			repeat (p.size_value) body.push_back(8'($urandom()));
		foreach (body[i])
			pending_bytes.push_back(body[i]);
	endfunction

	// offer one byte, with an occasional gap before it
	task automatic send_byte(input logic [7:0] b);
		if (gaps_on && $urandom_range(0, 5) == 0) begin
			data_valid <= 1'b0;
			repeat ($urandom_range(1, 16)) @(negedge clk);
		end
		data_valid <= 1'b1;
		data_byte <= b;
		@(posedge clk);
		while (data_ready !== 1'b1) @(posedge clk);
		ledger.take_byte(b);
		bytes_sent++;
		@(negedge clk);
	endtask

	task automatic send_pending();
		while (pending_bytes.size() != 0)
			send_byte(pending_bytes.pop_front());
	endtask

	task automatic send_random_frames(input int upto, input bit allow_gaps);
		while (bytes_sent < upto) begin
			gaps_on = allow_gaps && $urandom_range(0, 3) != 0;
			build_frame(random_plan());
			send_pending();
		end
	endtask

	initial begin
		frame_plan_t p;
		logic [2:0] kind;
		int unsigned need;
		int pick;
		repeat (6) @(negedge clk);
		arst_n <= 1'b1;

		// minimal progressive frame: no matrices, empty payload, no stuffing
		p = random_plan();
		p.interlace = 2'd0;
		p.qmats = 2'd0;
		p.fh_bytes = 16'd20;
		p.ph_len[0] = 5'd8;
		p.pic_bytes[0] = 32'd8;
		p.width = 16'h0000;
		p.height = 16'h0000;
		p.chroma = 2'd0;
		p.size_rule = SIZE_EXACT;
		build_frame(p);

		// two fields, both matrices, skipped bytes, longest picture header, stuffing
		p = random_plan();
		p.interlace = 2'd1;
		p.qmats = 2'd3;
		p.fh_bytes = 16'd151;
		p.ph_len = {5'd31, 5'd31};
		p.pic_bytes = {32'd31, 32'd36};
		p.width = 16'hFFFF;
		p.height = 16'hFFFF;
		p.chroma = 2'd3;
		p.size_rule = SIZE_PADDED;
		p.size_value = 32'd7;
		build_frame(p);

		// bottom field first, luma only, frame size zero so content overruns it
		p = random_plan();
		p.interlace = 2'd2;
		p.qmats = 2'd2;
		p.fh_bytes = 16'd84;
		p.chroma = 2'd1;
		p.size_rule = SIZE_SHORT;
		p.size_value = 32'd0;
		build_frame(p);

		// reserved interlace code is one picture; chroma matrix only, one skip byte
		p = random_plan();
		p.interlace = 2'd3;
		p.qmats = 2'd1;
		p.fh_bytes = 16'd85;
		p.chroma = 2'd2;
		p.size_rule = SIZE_PADDED;
		p.size_value = 32'd1;
		build_frame(p);
		send_pending();

		send_random_frames(1300, 1'b1);
		gaps_on = 1'b0;
		send_random_frames(1600, 1'b0);

		// one broken frame at the end, since the error holds until reset
		p = random_plan();
		p.size_rule = SIZE_GIVEN;
		p.size_value = ($urandom_range(0, 1) == 0) ? 32'hFFFF_FFFF : $urandom();
		pick = (p.interlace == 2'd1 || p.interlace == 2'd2) ? $urandom_range(0, 1) : 0;
		kind = 3'($urandom_range(ERR_BAD_ID, ERR_PHDR_SHORT));
		case (kind)
			ERR_BAD_ID:
				p.ident = FRAME_ID ^ ($urandom_range(1, 255) << (8 * $urandom_range(0, 3)));
			ERR_FHDR_SHORT: begin
				p.qmats = 2'($urandom_range(0, 3));
				need = 20 + (p.qmats[1] ? 64 : 0) + (p.qmats[0] ? 64 : 0);
				p.fh_bytes = 16'($urandom_range(0, need - 1));
			end
			ERR_PSIZE_SHORT: begin
				p.ph_len[pick] = 5'($urandom_range(1, 31));
				p.pic_bytes[pick] = $urandom_range(0, 32'(p.ph_len[pick]) - 1);
			end
			default: begin
				p.ph_len[pick] = 5'($urandom_range(0, 7));
				p.pic_bytes[pick] = ($urandom_range(0, 1) == 0) ? 32'hFFFF_FFFF :
					32'(p.ph_len[pick]) + $urandom_range(0, 50);
			end
		endcase
		build_frame(p);
		repeat ($urandom_range(8, 40)) pending_bytes.push_back(8'($urandom()));
		send_pending();
		data_valid <= 1'b0;

		// drain, then allow for the pipeline latency
		while (ledger.pending_results.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
		if (ledger.mismatches == 0 && ledger.pending_results.size() == 0)
			$display("** rdd36_frame_deframer_core: PASSED **");
		else
			$display("** rdd36_frame_deframer_core: FAILED **");
		$finish;
	end

endmodule
